// ===== rtl/core/stoalu_pkg.sv =====
// Shared opcodes, widths and result type for the scalar two-operand ALU.
package stoalu_pkg;

    localparam int unsigned OpW   = 6;
    localparam int unsigned DataW = 64;
    localparam int unsigned HalfW = 32;

    typedef enum logic [OpW-1:0] {
        OP_AND32      = 6'd0,  OP_AND64      = 6'd1,
        OP_OR32       = 6'd2,  OP_OR64       = 6'd3,
        OP_XOR32      = 6'd4,  OP_XOR64      = 6'd5,
        OP_ANDN2_32   = 6'd6,  OP_ANDN2_64   = 6'd7,
        OP_ORN2_32    = 6'd8,  OP_ORN2_64    = 6'd9,
        OP_NAND32     = 6'd10, OP_NAND64     = 6'd11,
        OP_NOR32      = 6'd12, OP_NOR64      = 6'd13,
        OP_XNOR32     = 6'd14, OP_XNOR64     = 6'd15,
        OP_SHL32      = 6'd16, OP_LSHR32     = 6'd17, OP_ASHR32 = 6'd18,
        OP_SHL64      = 6'd19, OP_LSHR64     = 6'd20, OP_ASHR64 = 6'd21,
        OP_ADD_U32    = 6'd22, OP_ADD_I32    = 6'd23,
        OP_SUB_U32    = 6'd24, OP_SUB_I32    = 6'd25,
        OP_ADDC_U32   = 6'd26, OP_SUBB_U32   = 6'd27,
        OP_MUL_LO32   = 6'd28, OP_MUL_HI_U32 = 6'd29, OP_MUL_HI_I32 = 6'd30,
        OP_MUL_LO64   = 6'd31, OP_ADD64      = 6'd32, OP_SUB64      = 6'd33,
        OP_MIN_I32    = 6'd34, OP_MIN_U32    = 6'd35,
        OP_MAX_I32    = 6'd36, OP_MAX_U32    = 6'd37,
        OP_LSHL1_ADD  = 6'd38, OP_LSHL2_ADD  = 6'd39,
        OP_LSHL3_ADD  = 6'd40, OP_LSHL4_ADD  = 6'd41,
        OP_ABSDIFF    = 6'd42, OP_BFM32      = 6'd43, OP_BFM64      = 6'd44,
        OP_BFE_U32    = 6'd45, OP_BFE_I32    = 6'd46, OP_BFE_I64    = 6'd47,
        OP_PACK_LL    = 6'd48, OP_PACK_LH    = 6'd49,
        OP_CSEL32     = 6'd50, OP_CSEL64     = 6'd51
    } t_op;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_BAD_OP  = 1'b1;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             flag;
        logic             status;
    } t_res;

endpackage

// ===== rtl/core/stoalu_core.sv =====
// Combinational datapath: one operation from registered operands and the flag.
module stoalu_core (
    input  logic [stoalu_pkg::OpW-1:0]   i_action,
    input  logic [stoalu_pkg::DataW-1:0] i_src0,
    input  logic [stoalu_pkg::DataW-1:0] i_src1,
    input  logic                         i_flag,
    output stoalu_pkg::t_res             o_res
);
    logic [31:0]  a32, b32, a_hi, b_hi;
    logic [63:0]  a, b, r, bw;
    logic         f, nz, st;
    logic [32:0]  add33, addc33, cmp_rhs;
    logic [31:0]  sub32, subb32, absd;
    logic [63:0]  p_ll;
    logic signed [63:0] p_ss;
    logic [31:0]  p_lh, p_hl;
    logic [36:0]  lsa;
    logic [4:0]   sh5, lsh5, rsh5;
    logic [5:0]   sh6, lsh6, rsh6;
    logic [6:0]   len;
    logic [7:0]   sum32, sum64;
    logic [31:0]  m32, bfe_u;
    logic [63:0]  m64;

    always_comb begin
        a     = i_src0;
        b     = i_src1;
        a32   = a[31:0];
        b32   = b[31:0];
        a_hi  = a[63:32];
        b_hi  = b[63:32];
        add33 = {1'b0, a32} + {1'b0, b32};
        addc33 = {1'b0, a32} + {1'b0, b32} + {32'd0, i_flag};
        sub32 = a32 - b32;
        subb32 = a32 - b32 - {31'd0, i_flag};
        cmp_rhs = {1'b0, b32} + {32'd0, i_flag};
        absd  = sub32[31] ? (32'd0 - sub32) : sub32;
        p_ll  = {32'd0, a32} * {32'd0, b32};
        p_ss  = $signed({{32{a32[31]}}, a32}) * $signed({{32{b32[31]}}, b32});
        p_lh  = a32 * b_hi;
        p_hl  = a_hi * b32;
        lsa   = ({5'd0, a32} << (i_action - 6'd37)) + {5'd0, b32};
        sh5   = b[4:0];
        sh6   = b[5:0];
        len   = b[22:16];
        sum32 = {3'd0, sh5} + {1'b0, len};
        sum64 = {2'd0, sh6} + {1'b0, len};
        lsh5  = 5'(6'd32 - sum32[5:0]);
        rsh5  = 5'(7'd32 - len);
        lsh6  = 6'(7'd64 - sum64[6:0]);
        rsh6  = 6'(7'd64 - len);
        m32   = (len >= 7'd32) ? 32'hffff_ffff : ((32'd1 << len[4:0]) - 32'd1);
        bfe_u = (a32 >> sh5) & m32;
        m64   = (64'd1 << a[5:0]) - 64'd1;

        case (i_action[3:1])
            3'd0:    bw = a & b;
            3'd1:    bw = a | b;
            3'd2:    bw = a ^ b;
            3'd3:    bw = a & ~b;
            3'd4:    bw = a | ~b;
            3'd5:    bw = ~(a & b);
            3'd6:    bw = ~(a | b);
            default: bw = ~(a ^ b);
        endcase

        r  = '0;
        f  = i_flag;
        nz = 1'b0;
        st = stoalu_pkg::ST_DONE;
        if (i_action < 6'd16) begin
            r  = i_action[0] ? bw : {32'd0, bw[31:0]};
            nz = 1'b1;
        end else begin
            case (i_action)
                stoalu_pkg::OP_SHL32:  begin r = {32'd0, a32 << sh5}; nz = 1'b1; end
                stoalu_pkg::OP_LSHR32: begin r = {32'd0, a32 >> sh5}; nz = 1'b1; end
                stoalu_pkg::OP_ASHR32: begin
                    r = {32'd0, 32'($signed(a32) >>> sh5)}; nz = 1'b1;
                end
                stoalu_pkg::OP_SHL64:  begin r = a << sh6; nz = 1'b1; end
                stoalu_pkg::OP_LSHR64: begin r = a >> sh6; nz = 1'b1; end
                stoalu_pkg::OP_ASHR64: begin r = 64'($signed(a) >>> sh6); nz = 1'b1; end
                stoalu_pkg::OP_ADD_U32: begin r = {32'd0, add33[31:0]}; f = add33[32]; end
                stoalu_pkg::OP_ADD_I32: begin
                    r = {32'd0, add33[31:0]};
                    f = (a32[31] ^ add33[31]) & (b32[31] ^ add33[31]);
                end
                stoalu_pkg::OP_SUB_U32: begin r = {32'd0, sub32}; f = a32 < b32; end
                stoalu_pkg::OP_SUB_I32: begin
                    r = {32'd0, sub32};
                    f = (a32[31] ^ b32[31]) & (a32[31] ^ sub32[31]);
                end
                stoalu_pkg::OP_ADDC_U32: begin r = {32'd0, addc33[31:0]}; f = addc33[32]; end
                stoalu_pkg::OP_SUBB_U32: begin
                    r = {32'd0, subb32}; f = {1'b0, a32} < cmp_rhs;
                end
                stoalu_pkg::OP_MUL_LO32:   r = {32'd0, p_ll[31:0]};
                stoalu_pkg::OP_MUL_HI_U32: r = {32'd0, p_ll[63:32]};
                stoalu_pkg::OP_MUL_HI_I32: r = {32'd0, p_ss[63:32]};
                // cross products only reach the upper word
                stoalu_pkg::OP_MUL_LO64:   r = p_ll + {p_lh + p_hl, 32'd0};
                stoalu_pkg::OP_ADD64:      r = a + b;
                stoalu_pkg::OP_SUB64:      r = a - b;
                stoalu_pkg::OP_MIN_I32: begin
                    f = $signed(a32) < $signed(b32); r = {32'd0, f ? a32 : b32};
                end
                stoalu_pkg::OP_MIN_U32: begin
                    f = a32 < b32; r = {32'd0, f ? a32 : b32};
                end
                stoalu_pkg::OP_MAX_I32: begin
                    f = $signed(a32) >= $signed(b32); r = {32'd0, f ? a32 : b32};
                end
                stoalu_pkg::OP_MAX_U32: begin
                    f = a32 >= b32; r = {32'd0, f ? a32 : b32};
                end
                stoalu_pkg::OP_LSHL1_ADD, stoalu_pkg::OP_LSHL2_ADD,
                stoalu_pkg::OP_LSHL3_ADD, stoalu_pkg::OP_LSHL4_ADD: begin
                    r = {32'd0, lsa[31:0]}; f = |lsa[36:32];
                end
                stoalu_pkg::OP_ABSDIFF: begin r = {32'd0, absd}; nz = 1'b1; end
                stoalu_pkg::OP_BFM32:
                    r = {32'd0, ((32'd1 << a[4:0]) - 32'd1) << sh5};
                stoalu_pkg::OP_BFM64: r = m64 << sh6;
                stoalu_pkg::OP_BFE_U32: begin
                    r = (len == 7'd0) ? '0 : {32'd0, bfe_u}; nz = 1'b1;
                end
                stoalu_pkg::OP_BFE_I32: begin
                    nz = 1'b1;
                    if (len == 7'd0)
                        r = '0;
                    else if (sum32 < 8'd32)
                        r = {32'd0, 32'($signed(a32 << lsh5) >>> rsh5)};
                    else
                        r = {32'd0, 32'($signed(a32) >>> sh5)};
                end
                stoalu_pkg::OP_BFE_I64: begin
                    nz = 1'b1;
                    if (len == 7'd0)
                        r = '0;
                    else if (sum64 < 8'd64)
                        r = 64'($signed(a << lsh6) >>> rsh6);
                    else
                        r = 64'($signed(a) >>> sh6);
                end
                stoalu_pkg::OP_PACK_LL: r = {32'd0, b[15:0], a[15:0]};
                stoalu_pkg::OP_PACK_LH: r = {32'd0, b[31:16], a[15:0]};
                stoalu_pkg::OP_CSEL32:  r = {32'd0, i_flag ? a32 : b32};
                stoalu_pkg::OP_CSEL64:  r = i_flag ? a : b;
                default: st = stoalu_pkg::ST_BAD_OP;
            endcase
        end
        if (nz)
            f = |r;
        o_res.result = r;
        o_res.flag   = f;
        o_res.status = st;
    end
endmodule

// ===== rtl/core/scalar_two_operand_alu.sv =====
// Scalar two-operand ALU top level: operand register, datapath, result register.
//  channel | dir | tdata (low bit up)              | tuser
//  s_axis  | in  | src0[63:0], src1[127:64]        | action[5:0]
//  m_axis  | out | result[63:0], flag_out[64], pad | status[0]
// An item passes through the operand register and then the result register; one item
// per cycle sustained while the output is not stalled.
// The flag register updates as an item with a supported opcode moves into the result
// register (an unsupported opcode leaves it as it was); the following item reads it.
// Reset clears the valid bits and the flag. A stalled output backs up one stage at a time.
module scalar_two_operand_alu (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // src0, src1
    input  logic [5:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // result, flag_out, zero pad
    output logic [0:0]   m_axis_tuser    // status
);
    logic                          r_in_vld, r_out_vld, r_flag;
    logic [stoalu_pkg::OpW-1:0]    r_action;
    logic [stoalu_pkg::DataW-1:0]  r_src0, r_src1;
    stoalu_pkg::t_res              r_res, w_res;
    logic                          adv, n_flag;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign n_flag        = (w_res.status == stoalu_pkg::ST_DONE) ? w_res.flag : r_flag;

    stoalu_core u_core (
        .i_action (r_action),
        .i_src0   (r_src0),
        .i_src1   (r_src1),
        .i_flag   (r_flag),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flag    <= 1'b0;
        end else begin
            if (s_axis_tready)
                r_in_vld <= s_axis_tvalid;
            if (adv) begin
                r_out_vld <= 1'b1;
                r_flag    <= n_flag;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser;
            r_src0   <= s_axis_tdata[63:0];
            r_src1   <= s_axis_tdata[127:64];
        end
        if (adv) begin
            r_res.result <= w_res.result;
            r_res.flag   <= n_flag;
            r_res.status <= w_res.status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_res.flag, r_res.result};
    assign m_axis_tuser  = r_res.status;

    a_flag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_flag)) else $error("flag changed without a transfer");
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_flag == r_res.flag)) else $error("flag register and result disagree");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.status == stoalu_pkg::ST_BAD_OP) |-> (r_res.result == '0))
        else $error("unsupported opcode gave nonzero result");
    a_bad_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && w_res.status == stoalu_pkg::ST_BAD_OP) |=> $stable(r_flag))
        else $error("unsupported opcode changed flag");
endmodule
